### rtl/bitmap_ready_queue_task_scheduler_unit_assert.svh
// assertion macros for the bitmap ready queue task scheduler
// used by brqts_checker, no other dependencies
`ifndef BITMAP_READY_QUEUE_TASK_SCHEDULER_UNIT_ASSERT_SVH
`define BITMAP_READY_QUEUE_TASK_SCHEDULER_UNIT_ASSERT_SVH

// same-cycle implication
`define BRQTS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define BRQTS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/brqts_pkg.sv
// shared constants and codes for the bitmap ready queue task scheduler
// no dependencies
package brqts_pkg;

  localparam int PRIO_LEVELS_DEF = 32;
  localparam int NODE_COUNT_DEF  = 64;

  localparam int KIND_W   = 2;
  localparam int IDX_W    = 6;
  localparam int TASK_W   = 6;
  localparam int RPRIO_W  = 6;
  localparam int DPRIO_W  = 8;
  localparam int IN_W     = 32;
  localparam int OUT_W    = 24;

  localparam logic [KIND_W-1:0] KIND_INSERT    = 2'd0;
  localparam logic [KIND_W-1:0] KIND_CHECK     = 2'd1;
  localparam logic [KIND_W-1:0] KIND_TERMINATE = 2'd2;

endpackage

### rtl/brqts_ram.sv
// generic single-write, single-read ram with registered read data
// depends on nothing
module brqts_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### rtl/bitmap_ready_queue_task_scheduler_unit.sv
// Bitmap ready queue task scheduler, top level. Uses brqts_pkg and brqts_ram.
// One request in gives one result out. Per-level FIFO ready queues keep head
// and tail in a level memory, the links and node attributes in two node
// memories, and the running stack in a stack memory; a bitmask register marks
// the non-empty levels and a priority encoder on it picks the highest level.
// Requests are handled one at a time, from the accepting cycle up to the load
// of the output register, as a chain of registered memory reads followed by
// write-backs: stack top, level entry, node link and attributes, then the new
// stack top and its task for the result. The next request is taken while a
// finished result still waits on the output register. No clearing pass after
// reset: memory entries are used only after being written.
module bitmap_ready_queue_task_scheduler_unit #(
  parameter int PRIO_LEVELS = brqts_pkg::PRIO_LEVELS_DEF,
  parameter int NODE_COUNT  = brqts_pkg::NODE_COUNT_DEF
) (
  input  logic        clk,
  input  logic        rst,
  // configuration: idle_task_id
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [5:0]  cfg_data,
  // request side
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [5:0] node_index, [11:6] task_id, [17:12] rdy_prio, [25:18] disp_prio
  input  logic [31:0] s_axis_tdata,
  // [1:0] kind
  input  logic [1:0]  s_axis_tuser,
  // result side
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [0] head_moved, [1] dispatched, [7:2] running_task, [8] running_is_idle,
  // [16:9] running_prio, [22:17] removed_node, [23] error
  output logic [23:0] m_axis_tdata
);

  localparam int L  = (PRIO_LEVELS > 1) ? $clog2(PRIO_LEVELS) : 1;
  localparam int N  = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;
  localparam int D  = $clog2(NODE_COUNT + 1);
  localparam int IW = brqts_pkg::TASK_W + L + brqts_pkg::DPRIO_W;
  localparam int SW = N + brqts_pkg::DPRIO_W;
  localparam logic [6:0] PL7   = 7'(PRIO_LEVELS);
  localparam logic [8:0] NC9   = 9'(NODE_COUNT);
  localparam logic [D-1:0] FULL = D'(NODE_COUNT);

  // one-hot sequencer states
  typedef enum logic [9:0] {
    S_IDLE     = 10'b0000000001,
    S_INS_LINK = 10'b0000000010,
    S_POP      = 10'b0000000100,
    S_CHK      = 10'b0000001000,
    S_CHK_PRIO = 10'b0000010000,
    S_DEQ      = 10'b0000100000,
    S_PUSH     = 10'b0001000000,
    S_TOP_RD   = 10'b0010000000,
    S_TOP_TASK = 10'b0100000000,
    S_FIN      = 10'b1000000000
  } state_t;

  state_t state, state_next;

  logic [PRIO_LEVELS-1:0] level_mask;
  logic [D-1:0]           depth;
  logic [5:0]             idle_task_id;

  // request fields
  logic [1:0] in_kind;
  logic [5:0] in_idx, in_task, in_rprio;
  logic [7:0] in_dprio;
  assign in_kind  = s_axis_tuser;
  assign in_idx   = s_axis_tdata[5:0];
  assign in_task  = s_axis_tdata[11:6];
  assign in_rprio = s_axis_tdata[17:12];
  assign in_dprio = s_axis_tdata[25:18];

  // working registers
  logic [N-1:0] cur_node;
  logic [L-1:0] cur_lv;
  logic [2*N-1:0] lvl_q;
  logic [7:0] top_prio;
  logic hc, disp, err;
  logic [5:0] removed;

  // output register
  logic       o_valid;
  logic [23:0] o_data;

  // memory ports
  logic           lvl_we, lvl_re, link_we, link_re, info_we, info_re, stk_we, stk_re;
  logic [L-1:0]   lvl_wa, lvl_ra;
  logic [2*N-1:0] lvl_wd, lvl_rd;
  logic [N-1:0]   link_wa, link_ra, link_wd, link_rd;
  logic [N-1:0]   info_wa, info_ra;
  logic [IW-1:0]  info_wd, info_rd;
  logic [N-1:0]   stk_wa, stk_ra;
  logic [SW-1:0]  stk_wd, stk_rd;

  brqts_ram #(.WIDTH(2*N), .DEPTH(PRIO_LEVELS)) u_level_ram (
    .clk, .we(lvl_we), .waddr(lvl_wa), .wdata(lvl_wd),
    .re(lvl_re), .raddr(lvl_ra), .rdata(lvl_rd)
  );
  brqts_ram #(.WIDTH(N), .DEPTH(NODE_COUNT)) u_link_ram (
    .clk, .we(link_we), .waddr(link_wa), .wdata(link_wd),
    .re(link_re), .raddr(link_ra), .rdata(link_rd)
  );
  brqts_ram #(.WIDTH(IW), .DEPTH(NODE_COUNT)) u_info_ram (
    .clk, .we(info_we), .waddr(info_wa), .wdata(info_wd),
    .re(info_re), .raddr(info_ra), .rdata(info_rd)
  );
  brqts_ram #(.WIDTH(SW), .DEPTH(NODE_COUNT)) u_stack_ram (
    .clk, .we(stk_we), .waddr(stk_wa), .wdata(stk_wd),
    .re(stk_re), .raddr(stk_ra), .rdata(stk_rd)
  );

  // highest non-empty level
  logic [L-1:0] top_lv;
  logic         mask_any;
  always_comb begin
    top_lv = '0;
    for (int i = 0; i < PRIO_LEVELS; i++) begin
      if (level_mask[i]) begin
        top_lv = L'(i);
      end
    end
  end
  assign mask_any = |level_mask;

  // clamped queue level of an insert
  logic [L-1:0] ins_lv;
  logic [6:0]   rp7;
  logic         idx_ok;
  assign rp7 = {1'b0, in_rprio};
  always_comb begin
    if (in_rprio == '0) begin
      ins_lv = '0;
    end else if (rp7 > PL7) begin
      ins_lv = L'(PRIO_LEVELS - 1);
    end else begin
      ins_lv = L'(rp7 - 7'd1);
    end
  end
  assign idx_ok = {3'b000, in_idx} < NC9;

  logic [D-1:0] depth_m1;
  assign depth_m1 = depth - 1'b1;

  // stacked entry fields
  logic [7:0]   stk_prio;
  logic [N-1:0] stk_node;
  assign stk_prio = stk_rd[7:0];
  assign stk_node = stk_rd[SW-1:8];

  // dispatch priority: max(ready level + 1, dispatch priority)
  logic [7:0] lv_plus, push_prio;
  assign lv_plus   = 8'(info_rd[L+5:6]) + 8'd1;
  assign push_prio = (lv_plus < info_rd[IW-1:L+6]) ? info_rd[IW-1:L+6] : lv_plus;

  logic out_free;
  assign out_free = !o_valid || m_axis_tready;

  assign s_axis_tready = (state == S_IDLE);
  assign cfg_ready     = 1'b1;
  assign m_axis_tvalid = o_valid;
  assign m_axis_tdata  = o_data;

  // sequencing and memory control
  always_comb begin
    state_next = state;
    lvl_we = 1'b0; lvl_re = 1'b0; lvl_wa = cur_lv; lvl_ra = cur_lv; lvl_wd = lvl_q;
    link_we = 1'b0; link_re = 1'b0; link_wa = cur_node; link_ra = cur_node;
    link_wd = cur_node;
    info_we = 1'b0; info_re = 1'b0; info_wa = N'(in_idx); info_ra = cur_node;
    info_wd = {in_dprio, ins_lv, in_task};
    stk_we = 1'b0; stk_re = 1'b0; stk_wa = depth[N-1:0]; stk_ra = depth_m1[N-1:0];
    stk_wd = {cur_node, push_prio};
    case (state)
      S_IDLE: begin
        if (s_axis_tvalid) begin
          case (in_kind)
            brqts_pkg::KIND_INSERT: begin
              if (idx_ok) begin
                info_we = 1'b1;
                if (!level_mask[ins_lv]) begin
                  lvl_we = 1'b1;
                  lvl_wa = ins_lv;
                  lvl_wd = {N'(in_idx), N'(in_idx)};
                  state_next = S_TOP_RD;
                end else begin
                  lvl_re = 1'b1;
                  lvl_ra = ins_lv;
                  state_next = S_INS_LINK;
                end
              end else begin
                state_next = S_TOP_RD;
              end
            end
            brqts_pkg::KIND_CHECK: state_next = S_CHK;
            brqts_pkg::KIND_TERMINATE: begin
              if (depth != '0) begin
                stk_re = 1'b1;
                state_next = S_POP;
              end else begin
                state_next = S_CHK;
              end
            end
            default: state_next = S_TOP_RD;
          endcase
        end
      end
      S_INS_LINK: begin
        // append behind the old tail
        link_we = 1'b1;
        link_wa = lvl_rd[N-1:0];
        link_wd = cur_node;
        lvl_we  = 1'b1;
        lvl_wd  = {lvl_rd[2*N-1:N], cur_node};
        state_next = S_TOP_RD;
      end
      S_POP: state_next = S_CHK;
      S_CHK: begin
        if (!mask_any) begin
          state_next = S_TOP_RD;
        end else if (depth != '0) begin
          stk_re = 1'b1;
          state_next = S_CHK_PRIO;
        end else begin
          lvl_re = 1'b1;
          lvl_ra = top_lv;
          state_next = S_DEQ;
        end
      end
      S_CHK_PRIO: begin
        if ({1'b0, stk_prio} >= 9'(cur_lv) + 9'd1) begin
          state_next = S_TOP_RD;
        end else if (depth == FULL) begin
          state_next = S_TOP_RD;
        end else begin
          lvl_re = 1'b1;
          state_next = S_DEQ;
        end
      end
      S_DEQ: begin
        link_re = 1'b1;
        link_ra = lvl_rd[2*N-1:N];
        info_re = 1'b1;
        info_ra = lvl_rd[2*N-1:N];
        state_next = S_PUSH;
      end
      S_PUSH: begin
        if (lvl_q[2*N-1:N] != lvl_q[N-1:0]) begin
          lvl_we = 1'b1;
          lvl_wd = {link_rd, lvl_q[N-1:0]};
        end
        stk_we = 1'b1;
        state_next = S_TOP_RD;
      end
      S_TOP_RD: begin
        if (depth != '0) begin
          stk_re = 1'b1;
          state_next = S_TOP_TASK;
        end else begin
          state_next = S_FIN;
        end
      end
      S_TOP_TASK: begin
        info_re = 1'b1;
        info_ra = stk_node;
        state_next = S_FIN;
      end
      S_FIN: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      level_mask   <= '0;
      depth        <= '0;
      idle_task_id <= '0;
      o_valid      <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_valid) begin
        idle_task_id <= cfg_data;
      end
      // a new result loads as the old one leaves
      if (state == S_FIN && out_free) begin
        o_valid <= 1'b1;
      end else if (o_valid && m_axis_tready) begin
        o_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (s_axis_tvalid && in_kind == brqts_pkg::KIND_INSERT && idx_ok) begin
            level_mask[ins_lv] <= 1'b1;
          end
        end
        S_POP: depth <= depth_m1;
        S_DEQ: begin
          if (lvl_rd[2*N-1:N] == lvl_rd[N-1:0]) begin
            level_mask[cur_lv] <= 1'b0;
          end
        end
        S_PUSH: depth <= depth + 1'b1;
        default: ;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        cur_node <= N'(in_idx);
        cur_lv   <= ins_lv;
        hc       <= 1'b0;
        disp     <= 1'b0;
        err      <= 1'b0;
        removed  <= '0;
        top_prio <= '0;
        if (s_axis_tvalid) begin
          if (in_kind == brqts_pkg::KIND_INSERT && idx_ok && !level_mask[ins_lv]) begin
            hc <= (level_mask >> ins_lv) == '0;
          end
          if (in_kind == brqts_pkg::KIND_TERMINATE && depth == '0) begin
            err <= 1'b1;
          end
        end
      end
      S_POP:  removed <= 6'(stk_node);
      S_CHK:  cur_lv  <= top_lv;
      S_CHK_PRIO: begin
        if (!({1'b0, stk_prio} >= 9'(cur_lv) + 9'd1) && depth == FULL) begin
          err <= 1'b1;
        end
      end
      S_DEQ: begin
        lvl_q    <= lvl_rd;
        cur_node <= lvl_rd[2*N-1:N];
      end
      S_PUSH: disp <= 1'b1;
      S_TOP_TASK: top_prio <= stk_prio;
      S_FIN: begin
        if (out_free) begin
          if (depth != '0) begin
            o_data <= {err, removed, top_prio, 1'b0, info_rd[5:0], disp, hc};
          end else begin
            o_data <= {err, removed, 8'd0, 1'b1, idle_task_id, disp, hc};
          end
        end
      end
      default: ;
    endcase
  end

endmodule

### rtl/brqts_checker.sv
// port-level checker for the bitmap ready queue task scheduler, with its bind
// depends on bitmap_ready_queue_task_scheduler_unit_assert.svh
`include "bitmap_ready_queue_task_scheduler_unit_assert.svh"

module brqts_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [23:0] m_axis_tdata
);

  `BRQTS_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "result changed while stalled")
  `BRQTS_ASSERT_NOW(a_idle_prio, m_axis_tvalid && m_axis_tdata[8], m_axis_tdata[16:9] == 8'd0, "idle with nonzero priority")
  `BRQTS_ASSERT_NOW(a_disp_not_idle, m_axis_tvalid && m_axis_tdata[1], !m_axis_tdata[8], "dispatch left idle running")
  `BRQTS_ASSERT_NOW(a_hc_no_disp, m_axis_tvalid && m_axis_tdata[0], !m_axis_tdata[1] && !m_axis_tdata[23], "insert result flagged dispatch or error")

endmodule

bind bitmap_ready_queue_task_scheduler_unit brqts_checker u_brqts_checker (.*);
